[src/assert_macros.svh]
// Assertion helpers shared by the queue modules.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/spq_pkg.sv]
package spq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int TAG_W             = 32;
    localparam int ORDER_W           = 16;
    localparam int COUNT_OUT_W       = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_cmd_t;

endpackage

[src/spq_cell.sv]
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_cmd_t                cmd,
    input  logic [TAG_W-1:0]         new_tag,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic [ORDER_W-1:0]       new_order,
    input  logic                     prev_valid,
    input  logic                     prev_after,
    input  logic [TAG_W-1:0]         prev_tag,
    input  logic [PRIORITY_BITS-1:0] prev_prio,
    input  logic [ORDER_W-1:0]       prev_order,
    input  logic                     next_valid,
    input  logic [TAG_W-1:0]         next_tag,
    input  logic [PRIORITY_BITS-1:0] next_prio,
    input  logic [ORDER_W-1:0]       next_order,
    output logic                     valid,
    output logic                     after,
    output logic [TAG_W-1:0]         tag,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic [ORDER_W-1:0]       order
);

    logic                     valid_reg, valid_next;
    logic [TAG_W-1:0]         tag_reg, tag_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic [ORDER_W-1:0]       order_reg, order_next;

    // The new word belongs behind this cell when this cell holds an entry
    // of equal or better priority.
    assign after = valid_reg && (prio_reg <= new_prio);

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        prio_next  = prio_reg;
        order_next = order_reg;
        if (cmd.pop)
        begin
            valid_next = next_valid;
            tag_next   = next_tag;
            prio_next  = next_prio;
            order_next = next_order;
        end
        else if (cmd.ins && !after)
        begin
            if (prev_after)
            begin
                valid_next = 1'b1;
                tag_next   = new_tag;
                prio_next  = new_prio;
                order_next = new_order;
            end
            else
            begin
                valid_next = prev_valid;
                tag_next   = prev_tag;
                prio_next  = prev_prio;
                order_next = prev_order;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        prio_reg  <= prio_next;
        order_reg <= order_next;
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign prio  = prio_reg;
    assign order = order_reg;

endmodule

[src/spq_ctrl.sv]
`include "assert_macros.svh"

module spq_ctrl
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int COUNT_W = $clog2(CAPACITY + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    output cell_cmd_t          cmd,
    output status_t            status_next,
    output logic               show_head,
    output logic [COUNT_W-1:0] count,
    output logic [ORDER_W-1:0] arrival
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ORDER_W-1:0] arrival_reg, arrival_next;
    logic               full;
    logic               empty;

    assign full  = (count_reg == COUNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb
    begin
        cmd          = '0;
        status_next  = ST_OK;
        show_head    = 1'b0;
        count_next   = count_reg;
        arrival_next = arrival_reg;
        case (op_t'(op))
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.ins      = start;
                    count_next   = count_reg + 1'b1;
                    arrival_next = arrival_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.pop    = start;
                    show_head  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    show_head = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            arrival_reg <= '0;
        end
        else if (start)
        begin
            count_reg   <= count_next;
            arrival_reg <= arrival_next;
        end
    end

    assign count   = count_reg;
    assign arrival = arrival_reg;

    `AST_SAME(a_count_bound, 1'b1, count_reg <= COUNT_W'(CAPACITY))
    `AST_NEXT(a_arrival_step, cmd.ins, arrival_reg == ORDER_W'($past(arrival_reg) + 1'b1))

endmodule

[src/stable_priority_queue_top.sv]
// Channel   Handshake           Fields
// --------  ------------------  ---------------------------------------------
// command   start / busy        op, job_tag, priority_req
// result    done (strobe only)  status, out_tag, out_priority, out_order,
//                               entry_count
//
// A command word is taken at any edge where start is high; busy stays low,
// so one operation can be issued every cycle.
// The result word appears in the cycle after its command and is flagged
// by done for one cycle only. The receiver has no way to stall it.
// Every cell of the chain compares its priority with the incoming one in
// parallel, and all cells load at the same edge.
// Reset clears the cell valid bits, the entry count and the arrival counter.
`include "assert_macros.svh"

module stable_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               op,
    input  logic [TAG_W-1:0]         job_tag,
    input  logic [PRIORITY_BITS-1:0] priority_req,
    output logic                     done,
    output logic [1:0]               status,
    output logic [TAG_W-1:0]         out_tag,
    output logic [PRIORITY_BITS-1:0] out_priority,
    output logic [ORDER_W-1:0]       out_order,
    output logic [COUNT_OUT_W-1:0]   entry_count
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    cell_cmd_t          cmd;
    status_t            status_next;
    logic               show_head;
    logic [COUNT_W-1:0] count;
    logic [ORDER_W-1:0] arrival;

    // Index 0 and CAPACITY+1 are the chain boundaries; cells sit at 1..CAPACITY,
    // with the queue head in cell 1.
    logic                     valid_a [0:CAPACITY+1];
    logic                     after_a [0:CAPACITY+1];
    logic [TAG_W-1:0]         tag_a   [0:CAPACITY+1];
    logic [PRIORITY_BITS-1:0] prio_a  [0:CAPACITY+1];
    logic [ORDER_W-1:0]       order_a [0:CAPACITY+1];
    logic [CAPACITY-1:0]      valid_vec;

    logic                     done_reg;
    status_t                  status_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [ORDER_W-1:0]       order_reg;

    // No operation can stall, so the block never pushes back.
    assign busy = 1'b0;

    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .cmd         (cmd),
        .status_next (status_next),
        .show_head   (show_head),
        .count       (count),
        .arrival     (arrival)
    );

    // The front boundary always lets a new word in ahead of the head cell; the
    // back boundary feeds an empty slot into the last cell on a pop.
    assign valid_a[0]          = 1'b0;
    assign after_a[0]          = 1'b1;
    assign tag_a[0]            = '0;
    assign prio_a[0]           = '0;
    assign order_a[0]          = '0;
    assign valid_a[CAPACITY+1] = 1'b0;
    assign after_a[CAPACITY+1] = 1'b0;
    assign tag_a[CAPACITY+1]   = '0;
    assign prio_a[CAPACITY+1]  = '0;
    assign order_a[CAPACITY+1] = '0;

    for (genvar i = 1; i <= CAPACITY; i++)
    begin : g_cell
        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .new_tag    (job_tag),
            .new_prio   (priority_req),
            .new_order  (arrival),
            .prev_valid (valid_a[i-1]),
            .prev_after (after_a[i-1]),
            .prev_tag   (tag_a[i-1]),
            .prev_prio  (prio_a[i-1]),
            .prev_order (order_a[i-1]),
            .next_valid (valid_a[i+1]),
            .next_tag   (tag_a[i+1]),
            .next_prio  (prio_a[i+1]),
            .next_order (order_a[i+1]),
            .valid      (valid_a[i]),
            .after      (after_a[i]),
            .tag        (tag_a[i]),
            .prio       (prio_a[i]),
            .order      (order_a[i])
        );
        assign valid_vec[i-1] = valid_a[i];
    end

    // Result registers. The head is sampled before the chain shifts, which is
    // what a remove must report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg <= status_next;
            tag_reg    <= show_head ? tag_a[1]   : '0;
            prio_reg   <= show_head ? prio_a[1]  : '0;
            order_reg  <= show_head ? order_a[1] : '0;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_tag      = tag_reg;
    assign out_priority = prio_reg;
    assign out_order    = order_reg;
    // The count register is updated at the same edge as the result registers.
    assign entry_count  = COUNT_OUT_W'(count);

    // The occupied cells always match the entry count.
    `AST_SAME(a_valid_count, 1'b1, $countones(valid_vec) == int'(count))
    `AST_NEXT(a_done_follows, start, done)
    `AST_SAME(a_empty_status, done && (status == ST_EMPTY), count == '0)

endmodule

[test/spq_checker.sv]
`timescale 1ns / 1ps

// Watches the command and result channels of the priority queue. It keeps a
// shadow copy of the sorted list and checks each result word, in order.
module spq_checker
    import spq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   op,
    input  logic [TAG_W-1:0]             job_tag,
    input  logic [PRIORITY_BITS_DEF-1:0] priority_req,
    input  logic                         done,
    input  logic [1:0]                   status,
    input  logic [TAG_W-1:0]             out_tag,
    input  logic [PRIORITY_BITS_DEF-1:0] out_priority,
    input  logic [ORDER_W-1:0]           out_order,
    input  logic [COUNT_OUT_W-1:0]       entry_count,
    output int                           error_count,
    output int                           awaited_count,
    output int                           words_checked
);

    localparam int MAX_REPORTS = 100;

    typedef struct {
        status_t                      status;
        logic [TAG_W-1:0]             tag;
        logic [PRIORITY_BITS_DEF-1:0] prio;
        logic [ORDER_W-1:0]           order;
        logic [COUNT_OUT_W-1:0]       count;
    } queue_reply_t;

    // Shadow of the sorted list; index 0 is the head.
    logic [TAG_W-1:0]             held_tag   [CAPACITY_DEF];
    logic [PRIORITY_BITS_DEF-1:0] held_prio  [CAPACITY_DEF];
    logic [ORDER_W-1:0]           held_order [CAPACITY_DEF];
    int                           held_total;
    logic [ORDER_W-1:0]           next_stamp;

    queue_reply_t awaited_replies [$];
    int           failures;
    int           reports;

    // Applies one command to the shadow list and returns the reply it should give.
    function automatic queue_reply_t serve_command(
        input logic [1:0]                   cmd,
        input logic [TAG_W-1:0]             tag,
        input logic [PRIORITY_BITS_DEF-1:0] prio
    );
        queue_reply_t reply;
        int           pos;
        reply.status = ST_OK;
        reply.tag    = '0;
        reply.prio   = '0;
        reply.order  = '0;
        if (cmd == OP_INSERT) begin
            if (held_total >= CAPACITY_DEF) begin
                reply.status = ST_FULL;
            end
            else begin
                // The new entry lands behind every entry of equal or lower value.
                pos = 0;
                while (pos < held_total && held_prio[pos] <= prio)
                    pos++;
                for (int k = held_total; k > pos; k--) begin
                    held_tag[k]   = held_tag[k-1];
                    held_prio[k]  = held_prio[k-1];
                    held_order[k] = held_order[k-1];
                end
                held_tag[pos]   = tag;
                held_prio[pos]  = prio;
                held_order[pos] = next_stamp;
                next_stamp      = next_stamp + 1'b1;
                held_total++;
            end
        end
        else if (cmd == OP_REMOVE || cmd == OP_PEEK) begin
            if (held_total == 0) begin
                reply.status = ST_EMPTY;
            end
            else begin
                reply.tag   = held_tag[0];
                reply.prio  = held_prio[0];
                reply.order = held_order[0];
                if (cmd == OP_REMOVE) begin
                    for (int k = 1; k < held_total; k++) begin
                        held_tag[k-1]   = held_tag[k];
                        held_prio[k-1]  = held_prio[k];
                        held_order[k-1] = held_order[k];
                    end
                    held_total--;
                end
            end
        end
        reply.count = COUNT_OUT_W'(held_total);
        return reply;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            failures++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, seen);
            else if (reports == MAX_REPORTS)
                $display("%0t: further mismatch reports suppressed", $time);
            reports++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_reply_t want;
        if (!rst_n) begin
            held_total = 0;
            next_stamp = '0;
            failures   = 0;
            reports    = 0;
            awaited_replies.delete();
            error_count   <= 0;
            awaited_count <= 0;
            words_checked <= 0;
        end
        else begin
            if (done === 1'b1) begin
                if (awaited_replies.size() == 0) begin
                    failures++;
                    $display("%0t: result word with none expected, status %0d",
                             $time, status);
                end
                else begin
                    want = awaited_replies.pop_front();
                    check_field("status", want.status, status);
                    check_field("out_tag", want.tag, out_tag);
                    check_field("out_priority", want.prio, out_priority);
                    check_field("out_order", want.order, out_order);
                    check_field("entry_count", want.count, entry_count);
                    words_checked <= words_checked + 1;
                end
            end
            else if (done !== 1'b0) begin
                failures++;
                $display("%0t: done is unknown, expected 0 or 1, actual %b", $time, done);
            end
            if (start === 1'b1 && busy === 1'b0)
                awaited_replies.push_back(serve_command(op, job_tag, priority_req));
            error_count   <= failures;
            awaited_count <= awaited_replies.size();
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

// Top of the priority queue bench. This module only produces command words
// and gives the verdict; the checker beside the block predicts and compares
// every result word.
module testbench;
    import spq_pkg::*;

    // The fourth op code has no meaning; the block must answer it with an OK
    // status and leave the queue alone.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 425;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   op;
    logic [TAG_W-1:0]             job_tag;
    logic [PRIORITY_BITS_DEF-1:0] priority_req;
    logic                         done;
    logic [1:0]                   status;
    logic [TAG_W-1:0]             out_tag;
    logic [PRIORITY_BITS_DEF-1:0] out_priority;
    logic [ORDER_W-1:0]           out_order;
    logic [COUNT_OUT_W-1:0]       entry_count;

    int   fail_total;
    int   awaited;
    int   checked;
    int   op_seen [4];
    logic calm;

    stable_priority_queue_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .job_tag      (job_tag),
        .priority_req (priority_req),
        .done         (done),
        .status       (status),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .out_order    (out_order),
        .entry_count  (entry_count)
    );

    spq_checker watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .job_tag       (job_tag),
        .priority_req  (priority_req),
        .done          (done),
        .status        (status),
        .out_tag       (out_tag),
        .out_priority  (out_priority),
        .out_order     (out_order),
        .entry_count   (entry_count),
        .error_count   (fail_total),
        .awaited_count (awaited),
        .words_checked (checked)
    );

    always #2 clk = ~clk;

    // A correct run takes well under a millisecond of simulated time, so this
    // only fires if the block stops answering or the handshake hangs.
    initial
    begin
        #3_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Puts one command word on the bus and holds it until the block takes it.
    // It is called at a rising edge and returns at the edge that accepted the
    // word, so back-to-back calls keep start high without a dip.
    task automatic send_word(input logic [1:0] code, input logic [TAG_W-1:0] tag,
                             input logic [PRIORITY_BITS_DEF-1:0] prio);
        start        <= 1'b1;
        op           <= code;
        job_tag      <= tag;
        priority_req <= prio;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        op_seen[code]++;
    endtask

    // Random idle cycles on the command side, each cycle idle with a chance
    // of 21 in 100. Skipped entirely while the calm flag is set.
    task automatic idle_maybe();
        while (!calm && $urandom_range(99) < 21) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin
        int mode;
        int roll;
        int t_ins;
        int t_rem;
        int t_peek;
        logic [1:0]                   code;
        logic [PRIORITY_BITS_DEF-1:0] prio;

        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_INSERT;
        job_tag      = '0;
        priority_req = '0;
        calm         = 1'b0;
        mode         = 0;
        for (int i = 0; i < 4; i++)
            op_seen[i] = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Remove, peek and the unused code on an empty queue
        // must all leave it untouched; the first two report empty.
        send_word(OP_PEEK, '0, '0);
        send_word(OP_REMOVE, '1, '1);
        send_word(OP_UNUSED, '1, '1);

        // Fill to capacity: extreme tags and priorities first, then a run of
        // equal priorities so the arrival order among ties gets checked,
        // interleaved with entries that have to be slotted in between.
        send_word(OP_INSERT, 32'h0000_0000, 8'hFF);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 8'h00);
        for (int i = 0; i < 6; i++)
            send_word(OP_INSERT, 32'hA5A5_0000 + i, 8'h80);
        for (int i = 0; i < 8; i++)
            send_word(OP_INSERT, $urandom, (i % 2 == 0) ? 8'h80 : 8'($urandom));

        // Queue is full now: an insert must report full and not take a stamp.
        send_word(OP_INSERT, 32'h1234_5678, 8'h00);
        send_word(OP_UNUSED, '0, '0);
        send_word(OP_PEEK, '0, '0);
        repeat (3) send_word(OP_REMOVE, '0, '0);

        // Random part. Every 40 words a new bias is drawn: fill (pushes the
        // queue into full), drain (pushes it into empty) or balanced. Half the
        // priorities come from a tiny range so ties are frequent.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 40 == 0)
                mode = $urandom_range(2);
            calm = (i >= 200 && i < 300);
            case (mode)
                0: begin
                    t_ins  = 70;
                    t_rem  = 82;
                    t_peek = 94;
                end
                1: begin
                    t_ins  = 20;
                    t_rem  = 75;
                    t_peek = 92;
                end
                default: begin
                    t_ins  = 42;
                    t_rem  = 74;
                    t_peek = 93;
                end
            endcase
            roll = $urandom_range(99);
            if (roll < t_ins)
                code = OP_INSERT;
            else if (roll < t_rem)
                code = OP_REMOVE;
            else if (roll < t_peek)
                code = OP_PEEK;
            else
                code = OP_UNUSED;
            prio = ($urandom_range(1) == 1) ? 8'($urandom_range(3)) : 8'($urandom);
            idle_maybe();
            send_word(code, $urandom, prio);
        end
        start <= 1'b0;

        // The count from the checker is registered, so let an edge pass before
        // looking at it, then let a few cycles pass for any stray result word.
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Issued %0d inserts, %0d removes, %0d peeks and %0d unused-code words;",
                 op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_PEEK],
                 op_seen[OP_UNUSED]);
        $display("%0d result words compared, through full, empty and priority ties.",
                 checked);
        if (fail_total == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/spq_ctrl.sv
src/stable_priority_queue_top.sv
test/spq_checker.sv
test/testbench.sv
